/* rtl/rod_pkg.sv */
// rod_pkg: field widths, threshold struct and bayer seed lookup for the
// rgb 332 ordered dither block; depends on nothing
package rod_pkg;

	localparam int unsigned CompW   = 8;
	localparam int unsigned CoordW  = 8;
	localparam int unsigned ColorW  = 8;
	localparam int unsigned Thr32W  = 5;
	localparam int unsigned Thr64W  = 6;

	typedef struct packed {
		logic [Thr32W-1:0] t32;
		logic [Thr64W-1:0] t64;
	} thr_t;

	typedef struct packed {
		logic [CompW-1:0] red;
		logic [CompW-1:0] green;
		logic [CompW-1:0] blue;
	} rgb_t;

	// 2x2 seed {0,3 / 2,1}, x across
	function automatic logic [1:0] seed_at(input logic xb, input logic yb);
		logic [1:0] s;
		case ({yb, xb})
			2'b00:   s = 2'd0;
			2'b01:   s = 2'd3;
			2'b10:   s = 2'd2;
			2'b11:   s = 2'd1;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/rod_pix_if.sv */
// rod_pix_if: valid/ready channel carrying one source pixel word
// uses rod_pkg for field widths
interface rod_pix_if;
	import rod_pkg::*;

	logic              valid;
	logic              ready;
	logic [CompW-1:0]  red;
	logic [CompW-1:0]  green;
	logic [CompW-1:0]  blue;
	logic [CoordW-1:0] column;
	logic [CoordW-1:0] row;

	modport source (output valid, red, green, blue, column, row, input ready);
	modport sink (input valid, red, green, blue, column, row, output ready);
endinterface

/* rtl/rod_color_if.sv */
// rod_color_if: valid/ready channel carrying one packed g3r3b2 word
// uses rod_pkg for field widths
interface rod_color_if;
	import rod_pkg::*;

	logic              valid;
	logic              ready;
	logic [ColorW-1:0] packed_color;

	modport source (output valid, packed_color, input ready);
	modport sink (input valid, packed_color, output ready);
endinterface

/* rtl/rod_thresh.sv */
// rod_thresh: 8x4 and 8x8 bayer threshold lookup from the low coordinate bits
// uses rod_pkg for seed_at and thr_t
module rod_thresh (
	input  logic [2:0]  col,
	input  logic [2:0]  rw,
	output rod_pkg::thr_t thr
);
	import rod_pkg::*;

	logic [1:0] s0, s1, s2;

	assign s0 = seed_at(col[0], rw[0]);
	assign s1 = seed_at(col[1], rw[1]);
	assign s2 = seed_at(col[2], rw[2]);

	always_comb begin
		thr.t32 = {s0, s1, col[2]};
		thr.t64 = {s0, s1, s2};
	end
endmodule

/* rtl/rod_quant.sv */
// rod_quant: per-component dither or truncation and g3r3b2 packing
// uses rod_pkg for rgb_t and thr_t
module rod_quant (
	input  rod_pkg::rgb_t            pix,
	input  rod_pkg::thr_t            thr,
	input  logic                     truncate,
	output logic [rod_pkg::ColorW-1:0] color
);
	import rod_pkg::*;

	function automatic logic [2:0] dither3(input logic [7:0] c, input logic [4:0] t);
		logic [3:0] v;
		v = {1'b0, c[7:5]} + {3'b000, (c[4:0] > t)};
		return (v == 4'd0) ? 3'd0 : 3'(v - 4'd1);
	endfunction

	logic [2:0] rq, gq;
	logic [1:0] bq;
	logic [2:0] bsum;

	always_comb begin
		bsum = {1'b0, pix.blue[7:6]} + {2'b00, (pix.blue[5:0] > thr.t64)};
		if (truncate) begin
			rq = pix.red[7:5];
			gq = pix.green[7:5];
			bq = pix.blue[7:6];
		end else begin
			rq = dither3(pix.red, thr.t32);
			gq = dither3(pix.green, thr.t32);
			bq = bsum[2] ? 2'd3 : bsum[1:0];
		end
		color = {gq, rq, bq};
	end
endmodule

/* rtl/rgb_ordered_dither_332.sv */
// rgb_ordered_dither_332: top level, input register, threshold and quantizer
// logic, result register; uses rod_pkg, rod_pix_if, rod_color_if,
// rod_thresh and rod_quant
//
//   channel  dir  word
//   pix      in   red, green, blue, column, row
//   color    out  packed_color
//   cfg      in   cfg_we, cfg_data (truncate_mode)
//
// one pixel per cycle sustained while color.ready is high; an accepted pixel passes
// the input register, then the result register, before color.valid rises
// arst_n clears both stage valids and truncate_mode
// a stalled result holds; pix.ready drops only when both stages are full
module rgb_ordered_dither_332 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	rod_pix_if.sink       pix,
	rod_color_if.source   color
);
	import rod_pkg::*;

	logic              truncate_q;
	logic              valid_s1, valid_s2;
	logic              ready_s1, ready_s2;
	rgb_t              rgb_s1;
	logic [2:0]        col_s1, row_s1;
	logic [ColorW-1:0] color_s2;
	thr_t              thr;
	logic [ColorW-1:0] color_d;

	assign ready_s2  = !valid_s2 || color.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			truncate_q <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (cfg_we)
				truncate_q <= cfg_data;
			if (ready_s1)
				valid_s1 <= pix.valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pix.valid) begin
			rgb_s1.red   <= pix.red;
			rgb_s1.green <= pix.green;
			rgb_s1.blue  <= pix.blue;
			col_s1       <= pix.column[2:0];
			row_s1       <= pix.row[2:0];
		end
		if (ready_s2 && valid_s1)
			color_s2 <= color_d;
	end

	rod_thresh u_thresh (
		.col (col_s1),
		.rw  (row_s1),
		.thr (thr)
	);

	rod_quant u_quant (
		.pix      (rgb_s1),
		.thr      (thr),
		.truncate (truncate_q),
		.color    (color_d)
	);

	assign color.valid        = valid_s2;
	assign color.packed_color = color_s2;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> valid_s1)
		else $error("accepted word did not reach stage 1");
	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("stage 1 word lost on the way to the result register");
	a_busy_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1)
		else $error("stage 1 word dropped during stall");
`endif
endmodule
